// ----- design/srtg_pkg.sv -----
// ----------------------------------------------------------------------------
// srtg_pkg
// Shared types and constants of the shift-register tone generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srtg_pkg;

  // Width of the tone pattern shift register.
  localparam int unsigned SHIFT_BITS = 24;

  // Widths fixed by the stream and register formats.
  localparam int unsigned SHIFT_DATA_W = 24;
  localparam int unsigned CTRL_W       = 8;
  localparam int unsigned PERIOD_W     = 8;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned S_TDATA_W    = 40;
  localparam int unsigned M_TDATA_W    = 24;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;

  // Reset values of the period registers.
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET = 8'd11;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET = 8'd44;

  // Register index taken from the word address bit.
  typedef enum logic {
    REG_FAST_PERIOD = 1'b0,
    REG_SLOW_PERIOD = 1'b1
  } reg_index_t;

  // Item kinds carried on tuser.
  typedef enum logic {
    MODE_FRAME_START = 1'b0,
    MODE_TICK        = 1'b1
  } mode_t;

  // Control byte bit positions.
  localparam int unsigned CTRL_FAST_BIT    = 5;
  localparam int unsigned CTRL_RECIRC_BIT  = 6;
  localparam int unsigned CTRL_ENABLE_BIT  = 7;

  // Added to the level to form the upper byte of the sample.
  localparam logic [7:0] LEVEL_BIAS = 8'h80;

  typedef struct packed {
    mode_t                   mode;
    logic [SHIFT_DATA_W-1:0] shift_data;
    logic                    noise_select;
    logic                    start_enable;
    logic                    irq_enable;
    logic [CTRL_W-1:0]       control_byte;
    logic                    random_bit;
    logic                    irq_clear;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                irq_raise;
  } result_t;

endpackage

`default_nettype wire

// ----- design/srtg_cfg.sv -----
// ----------------------------------------------------------------------------
// srtg_cfg
// APB register file holding the fast and slow shift periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srtg_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [srtg_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [srtg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [srtg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output logic      [srtg_pkg::PERIOD_W-1:0]      fast_period,
  output logic      [srtg_pkg::PERIOD_W-1:0]      slow_period
);
  import srtg_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period <= FAST_PERIOD_RESET;
      slow_period <= SLOW_PERIOD_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_FAST_PERIOD: fast_period <= pwdata[PERIOD_W-1:0];
        REG_SLOW_PERIOD: slow_period <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FAST_PERIOD: prdata = APB_DATA_W'(fast_period);
      REG_SLOW_PERIOD: prdata = APB_DATA_W'(slow_period);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/srtg_core.sv -----
// ----------------------------------------------------------------------------
// srtg_core
// Generator state and the single-pass sample and shift logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srtg_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire srtg_pkg::item_t               item,
  input  wire logic [srtg_pkg::PERIOD_W-1:0] fast_period,
  input  wire logic [srtg_pkg::PERIOD_W-1:0] slow_period,
  output srtg_pkg::result_t                  result
);
  import srtg_pkg::*;

  logic [SHIFT_BITS-1:0] pattern;
  logic [COUNT_W-1:0]    tick_count;
  logic                  noise_bit;
  logic                  noise_on;
  logic                  irq_on;
  logic                  irq_pending;

  logic                  enabled;
  logic                  recirc;
  logic [3:0]            volume;
  logic [PERIOD_W-1:0]   period;
  logic [COUNT_W-1:0]    count_inc;
  logic                  do_shift;
  logic                  pending_clr;
  logic                  raise;
  logic [7:0]            level;
  logic [SHIFT_BITS-1:0] pattern_shifted;

  assign volume      = item.control_byte[3:0];
  assign enabled     = item.control_byte[CTRL_ENABLE_BIT];
  assign recirc      = item.control_byte[CTRL_RECIRC_BIT];
  assign period      = item.control_byte[CTRL_FAST_BIT] ? fast_period : slow_period;
  assign count_inc   = tick_count + COUNT_W'(1);
  assign do_shift    = (count_inc >= period);
  assign pending_clr = irq_pending && !item.irq_clear;
  assign raise       = do_shift && enabled && irq_on && !pending_clr;

  // Level is zero or volume times sixteen; the bias turns it into the
  // upper byte of (level - 128) << 8.
  assign level = (enabled && (pattern[0] ^ noise_bit)) ? {volume, 4'b0000} : 8'h00;

  assign pattern_shifted = {recirc & pattern[0], pattern[SHIFT_BITS-1:1]};

  assign result.sample    = {level + LEVEL_BIAS, 8'h00};
  assign result.irq_raise = raise;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      tick_count  <= '0;
      noise_bit   <= 1'b0;
      noise_on    <= 1'b0;
      irq_on      <= 1'b0;
      irq_pending <= 1'b0;
    end else if (fire) begin
      if (item.mode == MODE_FRAME_START) begin
        pattern     <= SHIFT_BITS'(item.shift_data);
        noise_on    <= item.noise_select;
        irq_on      <= item.irq_enable;
        tick_count  <= '0;
        noise_bit   <= item.start_enable && item.noise_select && item.random_bit;
        irq_pending <= pending_clr;
      end else if (do_shift) begin
        pattern     <= pattern_shifted;
        tick_count  <= '0;
        noise_bit   <= enabled && noise_on && item.random_bit;
        irq_pending <= pending_clr || raise;
      end else begin
        tick_count  <= count_inc;
        irq_pending <= pending_clr;
      end
    end
  end

  // A raised interrupt leaves the flag pending.
  a_raise_sets_pending: assert property (@(posedge clk) disable iff (rst)
    fire && item.mode == MODE_TICK && raise |=> irq_pending)
    else $error("interrupt raised but not left pending");

  // No raise while an uncleared interrupt is pending.
  a_no_double_raise: assert property (@(posedge clk) disable iff (rst)
    raise |-> (!irq_pending || item.irq_clear))
    else $error("interrupt raised while still pending");

  // A frame start or a shift restarts the tick counter.
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    fire && (item.mode == MODE_FRAME_START || do_shift) |=> tick_count == '0)
    else $error("tick counter not restarted");

endmodule

`default_nettype wire

// ----- design/shift_register_tone_generator_top.sv -----
// ----------------------------------------------------------------------------
// shift_register_tone_generator_top
// Shift-register tone generator with stream ports and an APB period port.
// ----------------------------------------------------------------------------
// Each beat on the slave stream is either a frame start (tuser low), which
// loads the pattern and the noise and interrupt enables and produces no
// output, or a tick (tuser high), which produces exactly one master beat
// with a signed 16-bit sample and an interrupt-raise flag. The block takes
// one beat per cycle: a beat is registered at the input, the sample and the
// next generator state are formed in one pass of short logic, and the tick
// result lands in an output register, so a new beat can enter in every cycle
// while the downstream side keeps up. An accepted tick sits in the input
// register, then in the output register. Ticks stall only while the output
// register is full and not being drained; frame starts pass through the
// core even then. The fast and slow periods live at APB addresses 0 and 4
// and must only be written while the stream is idle.
`timescale 1ns / 1ps
`default_nettype none

module shift_register_tone_generator_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // APB configuration port.
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [srtg_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [srtg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [srtg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready,
  // Input stream.
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // From bit 0: shift_data[23:0], noise_select, start_enable, irq_enable,
  // control_byte[7:0], random_bit, irq_clear, then three zero bits.
  input  wire logic [srtg_pkg::S_TDATA_W-1:0]       s_tdata,
  // mode: 0 frame start, 1 tick.
  input  wire logic                                 s_tuser,
  // Output stream.
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // From bit 0: sample[15:0], irq_raise, then seven zero bits.
  output logic      [srtg_pkg::M_TDATA_W-1:0]       m_tdata
);
  import srtg_pkg::*;

  logic [PERIOD_W-1:0] fast_period;
  logic [PERIOD_W-1:0] slow_period;

  // Input register.
  logic    in_valid;
  item_t   in_item;
  item_t   s_item;
  logic    fire;

  // Output register.
  logic    out_valid;
  result_t out_result;
  result_t core_result;

  srtg_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fast_period (fast_period),
    .slow_period (slow_period)
  );

  // Unpack the input beat.
  always_comb begin
    s_item.mode         = mode_t'(s_tuser);
    s_item.shift_data   = s_tdata[23:0];
    s_item.noise_select = s_tdata[24];
    s_item.start_enable = s_tdata[25];
    s_item.irq_enable   = s_tdata[26];
    s_item.control_byte = s_tdata[34:27];
    s_item.random_bit   = s_tdata[35];
    s_item.irq_clear    = s_tdata[36];
  end

  // A registered item is processed when its result, if any, has room.
  assign fire     = in_valid &&
                    (in_item.mode == MODE_FRAME_START || !out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  srtg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (in_item),
    .fast_period (fast_period),
    .slow_period (slow_period),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_item.mode == MODE_TICK) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.mode == MODE_TICK) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0000000, out_result.irq_raise, out_result.sample};

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shift-register tone generator.
// ----------------------------------------------------------------------------
// Frame-start and tick beats go into the slave stream. The bench keeps its own
// model of the generator: pattern, tick counter, noise bit, enables, interrupt
// flag and both period registers. Every tick beat leaves one expected sample
// in a queue, and each output beat is compared with the oldest entry.
// A short table of hand-picked beats runs first. Where the answer is obvious,
// the table gives it. Three random phases follow, each with its own period
// setting and its own pattern of stalls on the two streams. The periods are
// changed over the APB port only while the stream is empty, and every write
// is read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import srtg_pkg::*;

  // A frame start leaves no output beat, so after the last expected sample
  // the core may still be busy with a frame start, so the bench waits longer.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 550;

  // One row of the directed table. Before the row runs, both periods can be
  // rewritten. When typed is set, the row gives its expected sample itself.
  typedef struct {
    bit                  write_periods;
    logic [PERIOD_W-1:0] fast;
    logic [PERIOD_W-1:0] slow;
    item_t               beat;
    bit                  typed;
    result_t             want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // From bit 0: shift_data[23:0], noise_select, start_enable, irq_enable,
  // control_byte[7:0], random_bit, irq_clear, three zero bits.
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  // mode: 0 frame start, 1 tick.
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // From bit 0: sample[15:0], irq_raise, seven zero bits.
  logic [M_TDATA_W-1:0]  m_tdata;

  // The bench's copy of the generator state and of the period registers.
  logic [SHIFT_BITS-1:0] tone_pattern;
  logic [COUNT_W-1:0]    tick_cnt;
  logic                  noise_bit;
  logic                  noise_on;
  logic                  irq_on;
  logic                  irq_pending;
  logic [PERIOD_W-1:0]   fast_period_now;
  logic [PERIOD_W-1:0]   slow_period_now;

  result_t               expected_tones[$];
  dir_row_t              directed_rows[$];
  result_t               tone_want;

  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    errors        = 0;
  int                    frames_sent   = 0;
  int                    ticks_sent    = 0;
  int                    tones_checked = 0;
  int                    irqs_seen     = 0;

  shift_register_tone_generator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Moves the generator model forward by one beat. The return value is 1 when
  // the beat is a tick, and then tone holds the sample it must produce.
  function automatic bit advance_tone(input item_t it, output result_t tone);
    logic [3:0]          volume;
    logic                enabled;
    logic                recirc;
    logic                tone_bit;
    logic [7:0]          level;
    logic [PERIOD_W-1:0] period;
    tone = '0;
    // A clear applies before the tick checks for a raise, so a tick can both
    // clear the flag and raise a new interrupt.
    if (it.irq_clear)
      irq_pending = 1'b0;
    if (it.mode == MODE_FRAME_START) begin
      tone_pattern = SHIFT_BITS'(it.shift_data);
      noise_on     = it.noise_select;
      irq_on       = it.irq_enable;
      tick_cnt     = '0;
      noise_bit    = it.start_enable & it.noise_select & it.random_bit;
      return 1'b0;
    end
    volume   = it.control_byte[3:0];
    enabled  = it.control_byte[CTRL_ENABLE_BIT];
    recirc   = it.control_byte[CTRL_RECIRC_BIT];
    period   = it.control_byte[CTRL_FAST_BIT] ? fast_period_now : slow_period_now;
    tone_bit = tone_pattern[0] ^ noise_bit;
    level    = (enabled && tone_bit) ? {volume, 4'h0} : 8'h00;
    // (level - 128) << 8 as a 16-bit value is the biased level in the top byte.
    tone.sample = {level + LEVEL_BIAS, 8'h00};
    tick_cnt = tick_cnt + COUNT_W'(1);
    // The test is "at least", so a zero period, or a period that drops below
    // the running count, shifts on this tick.
    if (tick_cnt >= period) begin
      tick_cnt     = '0;
      tone_pattern = {recirc & tone_pattern[0], tone_pattern[SHIFT_BITS-1:1]};
      noise_bit    = enabled & noise_on & it.random_bit;
      if (enabled && irq_on && !irq_pending) begin
        irq_pending    = 1'b1;
        tone.irq_raise = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic item_t frame_item(input logic [SHIFT_DATA_W-1:0] sdata,
                                       input logic nsel, input logic sen,
                                       input logic ien, input logic rbit,
                                       input logic clr);
    item_t it;
    it              = '0;
    it.mode         = MODE_FRAME_START;
    it.shift_data   = sdata;
    it.noise_select = nsel;
    it.start_enable = sen;
    it.irq_enable   = ien;
    it.random_bit   = rbit;
    it.irq_clear    = clr;
    return it;
  endfunction

  function automatic item_t tick_item(input logic [CTRL_W-1:0] ctrl,
                                      input logic rbit, input logic clr);
    item_t it;
    it              = '0;
    it.mode         = MODE_TICK;
    it.control_byte = ctrl;
    it.random_bit   = rbit;
    it.irq_clear    = clr;
    return it;
  endfunction

  function automatic void add_row(input bit wr, input logic [PERIOD_W-1:0] fast,
                                  input logic [PERIOD_W-1:0] slow, input item_t it,
                                  input bit typed, input logic [SAMPLE_W-1:0] sample);
    dir_row_t row;
    row.write_periods  = wr;
    row.fast           = fast;
    row.slow           = slow;
    row.beat           = it;
    row.typed          = typed;
    row.want.sample    = sample;
    row.want.irq_raise = 1'b0;
    directed_rows.push_back(row);
  endfunction

  // Sends one beat on the slave stream, with random idle cycles in front of
  // it. The expectation is queued before the beat can be accepted, so it is
  // always in place ahead of its output beat. When no idle cycle is drawn,
  // tvalid stays high from the previous beat and only the data changes.
  task automatic send_beat(input item_t it, input bit typed, input result_t want);
    result_t tone;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    if (advance_tone(it, tone))
      expected_tones.push_back(typed ? want : tone);
    if (it.mode == MODE_TICK)
      ticks_sent++;
    else
      frames_sent++;
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {3'b000, it.irq_clear, it.random_bit, it.control_byte,
                 it.irq_enable, it.start_enable, it.noise_select, it.shift_data};
    do @(posedge clk); while (!s_tready);
  endtask

  // Empties the stream. The periods may be written once this returns.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_tones.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one period register, then reads it back. Random bits are placed in
  // the upper part of pwdata. The register keeps only the low byte. The read
  // setup follows the write access directly, so psel stays high. An idle
  // bus state with psel low closes the transfer.
  task automatic set_period(input reg_index_t idx, input logic [PERIOD_W-1:0] val);
    logic [APB_DATA_W-1:0] wdata;
    wdata        = $urandom;
    wdata[7:0]   = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FAST_PERIOD)
      fast_period_now = val;
    else
      slow_period_now = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(APB_DATA_W-PERIOD_W){1'b0}}, val})
      report_mismatch(idx == REG_FAST_PERIOD ? "fast_period readback"
                                             : "slow_period readback",
                      prdata, 32'(val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic. Most of it is made of realistic frames: a frame start
  // followed by a run of ticks. Within a run, the ticks mostly repeat one
  // control byte, but some take a random one. A few beats are lone random
  // beats, which may be frame starts with no ticks after them. Ticks ignore
  // the frame fields. These fields still get random values on ticks.
  task automatic run_phase(input int n_beats);
    int               sent;
    int               run_len;
    logic [CTRL_W-1:0] base_ctrl;
    logic [CTRL_W-1:0] ctrl;
    item_t            it;
    result_t          none;
    none = '0;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 19) == 0) begin
        it            = tick_item(CTRL_W'($urandom), 1'($urandom), 1'($urandom));
        it.mode       = mode_t'($urandom_range(0, 1));
        it.shift_data = SHIFT_DATA_W'($urandom);
        it.noise_select = 1'($urandom);
        it.start_enable = 1'($urandom);
        it.irq_enable = 1'($urandom);
        send_beat(it, 1'b0, none);
        sent++;
      end else begin
        it = frame_item(SHIFT_DATA_W'($urandom), $urandom_range(0, 3) != 0,
                        $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                        1'($urandom), $urandom_range(0, 5) == 0);
        send_beat(it, 1'b0, none);
        sent++;
        run_len   = $urandom_range(4, 60);
        base_ctrl = CTRL_W'($urandom);
        if ($urandom_range(0, 3) != 0)
          base_ctrl[CTRL_ENABLE_BIT] = 1'b1;
        repeat (run_len) begin
          ctrl = ($urandom_range(0, 3) == 0) ? CTRL_W'($urandom) : base_ctrl;
          it = tick_item(ctrl, 1'($urandom), $urandom_range(0, 9) == 0);
          it.shift_data   = SHIFT_DATA_W'($urandom);
          it.noise_select = 1'($urandom);
          it.start_enable = 1'($urandom);
          it.irq_enable   = 1'($urandom);
          send_beat(it, 1'b0, none);
          sent++;
        end
      end
    end
  endtask

  // Output side. m_tready stalls at random. Each output beat is compared field
  // by field with the oldest expected sample, and the pad bits must be zero.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tones.size() == 0) begin
        report_mismatch("output beat with nothing expected", 32'(m_tdata), '0);
      end else begin
        tone_want = expected_tones.pop_front();
        tones_checked++;
        if (m_tdata[15:0] !== tone_want.sample)
          report_mismatch("sample", 32'(m_tdata[15:0]), 32'(tone_want.sample));
        if (m_tdata[16] !== tone_want.irq_raise)
          report_mismatch("irq_raise", 32'(m_tdata[16]), 32'(tone_want.irq_raise));
        if (m_tdata[M_TDATA_W-1:17] !== '0)
          report_mismatch("m_tdata pad bits", 32'(m_tdata[M_TDATA_W-1:17]), '0);
        if (m_tdata[16] === 1'b1)
          irqs_seen++;
      end
    end
  end

  // Stimulus, and the result at the end.
  initial begin
    tone_pattern    = '0;
    tick_cnt        = '0;
    noise_bit       = 1'b0;
    noise_on        = 1'b0;
    irq_on          = 1'b0;
    irq_pending     = 1'b0;
    fast_period_now = FAST_PERIOD_RESET;
    slow_period_now = SLOW_PERIOD_RESET;

    // The first rows run at the reset periods, 11 and 44.
    // A tick straight after reset sees an all-zero pattern and gives the
    // lowest sample.
    add_row(0, 0, 0, tick_item(8'h00, 1'b0, 1'b0), 1, 16'h8000);
    add_row(0, 0, 0, tick_item(8'hFF, 1'b1, 1'b0), 1, 16'h8000);
    // Load an all-ones pattern with noise off, and clear the interrupt flag.
    add_row(0, 0, 0, frame_item(24'hFFFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1), 0, '0);
    // Full volume gives the top sample. A disabled tick gives the lowest one.
    // Volume one gives one step above the lowest.
    add_row(0, 0, 0, tick_item(8'h8F, 1'b0, 1'b0), 1, 16'h7000);
    add_row(0, 0, 0, tick_item(8'h0F, 1'b0, 1'b0), 1, 16'h8000);
    add_row(0, 0, 0, tick_item(8'h81, 1'b0, 1'b0), 1, 16'h9000);
    // With a zero slow period, every slow tick shifts. The first shift raises
    // the interrupt. A later tick clears the flag and raises a new one.
    add_row(1, 8'd1, 8'd0, frame_item(24'h000001, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'hCF, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'hEF, 1'b0, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'hAF, 1'b1, 1'b1), 0, '0);
    add_row(0, 0, 0, tick_item(8'h80, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'h10, 1'b1, 1'b0), 1, 16'h8000);
    // Both period extremes. The noise draw at frame start is off, and so are
    // interrupts.
    add_row(1, 8'd255, 8'd1, frame_item(24'hA5A5A5, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'h9F, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'hBF, 1'b1, 1'b0), 0, '0);
    // Two fast ticks build up the count. A slow tick with period one then
    // finds the count above its period and shifts at once.
    add_row(0, 0, 0, frame_item(24'h5A5A5A, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1), 0, '0);
    add_row(0, 0, 0, tick_item(8'hA8, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'hA8, 1'b0, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'hC8, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'h48, 1'b1, 1'b0), 1, 16'h8000);
    add_row(0, 0, 0, frame_item(24'h000000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'h8F, 1'b1, 1'b0), 0, '0);
    add_row(0, 0, 0, tick_item(8'h7F, 1'b1, 1'b1), 1, 16'h8000);

    send_idle_pct = 13;
    recv_idle_pct = 65;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].write_periods) begin
        wait_idle();
        set_period(REG_FAST_PERIOD, directed_rows[i].fast);
        set_period(REG_SLOW_PERIOD, directed_rows[i].slow);
      end
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end

    // First random phase: short random periods. The sender is mostly busy and
    // the receiver stalls often.
    wait_idle();
    set_period(REG_FAST_PERIOD, PERIOD_W'($urandom_range(1, 6)));
    set_period(REG_SLOW_PERIOD, PERIOD_W'($urandom_range(7, 30)));
    run_phase(PHASE_BEATS);

    // Second phase: the two period extremes, with the stall pattern reversed.
    wait_idle();
    send_idle_pct = 65;
    recv_idle_pct = 13;
    set_period(REG_FAST_PERIOD, 8'd1);
    set_period(REG_SLOW_PERIOD, 8'd255);
    run_phase(PHASE_BEATS);

    // Third phase: random small periods, at full rate on both sides.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_period(REG_FAST_PERIOD, PERIOD_W'($urandom_range(1, 12)));
    set_period(REG_SLOW_PERIOD, PERIOD_W'($urandom_range(1, 20)));
    run_phase(PHASE_BEATS);

    wait_idle();
    $display("Sent %0d frame starts and %0d ticks under six period settings.",
             frames_sent, ticks_sent);
    $display("Checked %0d samples, %0d of which raised the interrupt; %0d mismatches.",
             tones_checked, irqs_seen, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog. A correct run takes a small fraction of this time.
  initial begin
    #2000000;
    $display("Timed out with %0d samples still expected.", expected_tones.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
design/srtg_pkg.sv
design/srtg_cfg.sv
design/srtg_core.sv
design/shift_register_tone_generator_top.sv
bench/tb_top.sv
